>>> sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks sampled on the rising clock edge and held off while reset is high.
`define KLS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Checks that must also hold across the reset itself.
`define KLS_ASSERT_NORST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/kls_pkg.sv
package kls_pkg;

  localparam int MAX_WORD  = 16;
  localparam int LEN_W     = $clog2(MAX_WORD + 1);
  localparam int IDX_W     = $clog2(MAX_WORD);
  localparam int CMD_DEPTH = 4;
  localparam int PTR_W     = $clog2(CMD_DEPTH);
  localparam int CNT_W     = $clog2(CMD_DEPTH + 1);
  localparam int NUM_KW    = 6;
  localparam int KW_MAXLEN = 5;

  typedef logic [4:0] kind_t;
  typedef logic [7:0] char_t;
  typedef logic [LEN_W-1:0] len_t;

  localparam kind_t KIND_VAR    = 5'd0;
  localparam kind_t KIND_INT    = 5'd1;
  localparam kind_t KIND_KW0    = 5'd2;
  localparam kind_t KIND_SEMI   = 5'd8;
  localparam kind_t KIND_ASSIGN = 5'd9;
  localparam kind_t KIND_PLUS   = 5'd10;
  localparam kind_t KIND_MINUS  = 5'd11;
  localparam kind_t KIND_DIV    = 5'd12;
  localparam kind_t KIND_MUL    = 5'd13;
  localparam kind_t KIND_LT     = 5'd14;
  localparam kind_t KIND_GT     = 5'd15;
  localparam kind_t KIND_LPAREN = 5'd16;
  localparam kind_t KIND_RPAREN = 5'd17;
  localparam kind_t KIND_ERR    = 5'd18;

  // Keywords in priority order: if, fi, then, while, do, done.
  localparam char_t KW_TEXT [NUM_KW][KW_MAXLEN] = '{
    '{"i", "f", 8'd0, 8'd0, 8'd0},
    '{"f", "i", 8'd0, 8'd0, 8'd0},
    '{"t", "h", "e", "n", 8'd0},
    '{"w", "h", "i", "l", "e"},
    '{"d", "o", 8'd0, 8'd0, 8'd0},
    '{"d", "o", "n", "e", 8'd0}
  };
  localparam len_t KW_LEN [NUM_KW] = '{
    LEN_W'(2), LEN_W'(2), LEN_W'(4), LEN_W'(5), LEN_W'(2), LEN_W'(4)
  };

  // One command from the classifier to the emitter.
  typedef struct packed {
    logic  append;
    logic  flush;
    logic  drop;
    logic  single;
    kind_t flush_kind;
    kind_t single_kind;
    char_t ch;
  } cmd_t;

  function automatic logic is_alpha(input char_t c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic is_digit(input char_t c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_space(input char_t c);
    return c inside {8'd32, [8'd9:8'd13]};
  endfunction

  function automatic kind_t delim_kind(input char_t c);
    kind_t k;
    case (c)
      ";":     k = KIND_SEMI;
      "=":     k = KIND_ASSIGN;
      "+":     k = KIND_PLUS;
      "-":     k = KIND_MINUS;
      "/":     k = KIND_DIV;
      "*":     k = KIND_MUL;
      "<":     k = KIND_LT;
      ">":     k = KIND_GT;
      "(":     k = KIND_LPAREN;
      ")":     k = KIND_RPAREN;
      default: k = KIND_ERR;
    endcase
    return k;
  endfunction

  function automatic char_t kw_char(input int k, input len_t p);
    char_t c;
    c = 8'd0;
    if (p < LEN_W'(KW_MAXLEN)) begin
      c = KW_TEXT[k][p[2:0]];
    end
    return c;
  endfunction

endpackage

>>> sv/kls_fifo.sv
module kls_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  kls_pkg::cmd_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output kls_pkg::cmd_t rd_data,
  output logic          empty
);

  kls_pkg::cmd_t                 mem [kls_pkg::CMD_DEPTH];
  logic [kls_pkg::PTR_W-1:0]     wr_ptr;
  logic [kls_pkg::PTR_W-1:0]     rd_ptr;
  logic [kls_pkg::CNT_W-1:0]     count;

  assign full    = count == kls_pkg::CNT_W'(kls_pkg::CMD_DEPTH);
  assign empty   = count == '0;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // The depth is a power of two, so the pointers simply wrap.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + kls_pkg::PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + kls_pkg::PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + kls_pkg::CNT_W'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - kls_pkg::CNT_W'(1);
      end
    end
  end

endmodule

>>> sv/kls_front.sv
module kls_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [7:0]    in_char,
  input  logic          end_of_text,
  input  logic          q_full,
  output logic          cmd_valid,
  output kls_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {M_IDLE, M_WORD, M_NUM, M_SKIP} mode_t;

  mode_t                      mode, mode_next;
  kls_pkg::len_t              len, len_next;
  logic [kls_pkg::NUM_KW-1:0] match, match_next;
  logic                       accept;
  logic                       alpha, digit, space;
  kls_pkg::kind_t             word_kind, run_kind;

  assign accept = push && !q_full;
  assign alpha  = kls_pkg::is_alpha(in_char);
  assign digit  = kls_pkg::is_digit(in_char);
  assign space  = kls_pkg::is_space(in_char);

  // Keyword matching is tracked one character at a time, so only the length
  // check remains when the word ends. The lowest keyword index wins.
  always_comb begin
    word_kind = kls_pkg::KIND_VAR;
    for (int k = kls_pkg::NUM_KW - 1; k >= 0; k--) begin
      if (match[k] && len == kls_pkg::KW_LEN[k]) begin
        word_kind = kls_pkg::KIND_KW0 + kls_pkg::kind_t'(k);
      end
    end
    run_kind = (mode == M_WORD) ? word_kind : kls_pkg::KIND_INT;
  end

  always_comb begin
    cmd             = '0;
    cmd.ch          = in_char;
    cmd.flush_kind  = run_kind;
    cmd.single_kind = kls_pkg::delim_kind(in_char);
    mode_next       = mode;
    len_next        = len;
    match_next      = match;
    if (end_of_text) begin
      cmd.flush = (mode == M_WORD || mode == M_NUM) && len != '0;
      mode_next = M_IDLE;
      len_next  = '0;
    end else begin
      case (mode)
        M_WORD, M_NUM: begin
          if (digit || (mode == M_WORD && alpha)) begin
            if (len < kls_pkg::LEN_W'(kls_pkg::MAX_WORD)) begin
              cmd.append = 1'b1;
              len_next   = len + kls_pkg::LEN_W'(1);
              for (int k = 0; k < kls_pkg::NUM_KW; k++) begin
                match_next[k] = match[k] && len < kls_pkg::KW_LEN[k] &&
                                in_char == kls_pkg::kw_char(k, len);
              end
            end else begin
              cmd.drop        = 1'b1;
              cmd.single      = 1'b1;
              cmd.single_kind = kls_pkg::KIND_ERR;
              mode_next       = M_SKIP;
              len_next        = '0;
            end
          end else if (alpha) begin
            // A letter straight after a number.
            cmd.drop        = 1'b1;
            cmd.single      = 1'b1;
            cmd.single_kind = kls_pkg::KIND_ERR;
            mode_next       = M_SKIP;
            len_next        = '0;
          end else begin
            cmd.flush  = 1'b1;
            cmd.single = !space;
            mode_next  = M_IDLE;
            len_next   = '0;
          end
        end
        M_SKIP: begin
          if (!(alpha || digit)) begin
            cmd.single = !space;
            mode_next  = M_IDLE;
          end
        end
        default: begin
          if (alpha || digit) begin
            cmd.append = 1'b1;
            mode_next  = alpha ? M_WORD : M_NUM;
            len_next   = kls_pkg::LEN_W'(1);
            for (int k = 0; k < kls_pkg::NUM_KW; k++) begin
              match_next[k] = in_char == kls_pkg::kw_char(k, '0);
            end
          end else begin
            cmd.single = !space;
          end
        end
      endcase
    end
    cmd_valid = accept && (cmd.append || cmd.flush || cmd.drop || cmd.single);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= M_IDLE;
      len   <= '0;
      match <= '0;
    end else if (accept) begin
      mode  <= mode_next;
      len   <= len_next;
      match <= match_next;
    end
  end

endmodule

>>> sv/kls_back.sv
module kls_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  kls_pkg::cmd_t cmd,
  output logic          q_pop,
  input  logic          pop,
  output logic          empty,
  output logic [4:0]    token_kind,
  output logic [7:0]    token_char,
  output logic          token_last
);

  typedef enum logic [1:0] {B_IDLE, B_EMIT, B_SINGLE} state_t;

  state_t                    state;
  kls_pkg::char_t            word_buf [kls_pkg::MAX_WORD];
  kls_pkg::len_t             wlen;
  logic [kls_pkg::IDX_W-1:0] idx;
  kls_pkg::kind_t            fkind;
  kls_pkg::kind_t            skind;
  kls_pkg::char_t            sch;
  logic                      pend_single;
  logic                      out_valid;
  logic                      load;
  logic                      emit_now;
  logic                      last_char;

  assign load      = !out_valid || pop;
  assign emit_now  = load && (state == B_EMIT || state == B_SINGLE);
  assign q_pop     = state == B_IDLE && !q_empty;
  assign empty     = !out_valid;
  assign last_char = (kls_pkg::LEN_W'(idx) + kls_pkg::LEN_W'(1)) == wlen;

  // The classifier never appends to a full buffer.
  always_ff @(posedge clk) begin
    if (q_pop && cmd.append) begin
      word_buf[wlen[kls_pkg::IDX_W-1:0]] <= cmd.ch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      wlen      <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit_now) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (q_pop) begin
            fkind       <= cmd.flush_kind;
            skind       <= cmd.single_kind;
            sch         <= cmd.ch;
            pend_single <= cmd.single;
            idx         <= '0;
            if (cmd.append) begin
              wlen <= wlen + kls_pkg::LEN_W'(1);
            end else if (cmd.drop) begin
              wlen <= '0;
            end
            if (cmd.flush && wlen != '0) begin
              state <= B_EMIT;
            end else if (cmd.single) begin
              state <= B_SINGLE;
            end
          end
        end
        B_EMIT: begin
          if (load) begin
            token_kind <= fkind;
            token_char <= word_buf[idx];
            token_last <= last_char;
            idx        <= idx + kls_pkg::IDX_W'(1);
            if (last_char) begin
              wlen  <= '0;
              state <= pend_single ? B_SINGLE : B_IDLE;
            end
          end
        end
        B_SINGLE: begin
          if (load) begin
            token_kind <= skind;
            token_char <= sch;
            token_last <= 1'b1;
            state      <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

>>> sv/keyword_lexer_stream.sv
// Path: an item's command is written to the command queue, taken by the emitter
// in its idle state, then registered on the output from its emit or single state.
// Throughput: one character per cycle while the four-entry command queue has
// room; the emitter emits all of a command's output before it takes the next.
// Reset: synchronous rst clears the lexer mode, counts, queue and output valid;
// the word buffer contents are not cleared.
module keyword_lexer_stream (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_char,
  input  logic       end_of_text,
  output logic       empty,
  input  logic       pop,
  output logic [4:0] token_kind,
  output logic [7:0] token_char,
  output logic       token_last
);

  kls_pkg::cmd_t wr_cmd;
  kls_pkg::cmd_t rd_cmd;
  logic          wr_en;
  logic          q_full;
  logic          q_empty;
  logic          q_pop;

  assign full = q_full;

  kls_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .in_char     (in_char),
    .end_of_text (end_of_text),
    .q_full      (q_full),
    .cmd_valid   (wr_en),
    .cmd         (wr_cmd)
  );

  kls_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_data (wr_cmd),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (rd_cmd),
    .empty   (q_empty)
  );

  kls_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .cmd        (rd_cmd),
    .q_pop      (q_pop),
    .pop        (pop),
    .empty      (empty),
    .token_kind (token_kind),
    .token_char (token_char),
    .token_last (token_last)
  );

endmodule

>>> sv/kls_checker.sv
`include "assert_macros.svh"

module kls_checker (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [4:0] token_kind,
  input logic [7:0] token_char,
  input logic       token_last
);

  `KLS_ASSERT_NORST(a_reset_empty, rst |=> empty, "result queue not empty after reset")
  `KLS_ASSERT_NORST(a_reset_not_full, rst |=> !full, "input blocked after reset")
  `KLS_ASSERT(a_hold,
              (!empty && !pop) |=> (!empty && $stable(token_kind) &&
                                    $stable(token_char) && $stable(token_last)),
              "waiting result changed")
  `KLS_ASSERT(a_kind_range, !empty |-> token_kind <= kls_pkg::KIND_ERR,
              "token kind out of range")
  `KLS_ASSERT(a_single_last, (!empty && token_kind >= kls_pkg::KIND_SEMI) |-> token_last,
              "one-character token without last mark")

endmodule

bind keyword_lexer_stream kls_checker u_kls_checker (.*);
